### rtl/half_bit_tick_uart_transceiver_macros.svh
// Assertion macros shared by the half-bit tick UART transceiver RTL.
`ifndef HALF_BIT_TICK_UART_TRANSCEIVER_MACROS_SVH
`define HALF_BIT_TICK_UART_TRANSCEIVER_MACROS_SVH

`ifndef SYNTHESIS
// Same-cycle implication, disabled while reset is asserted.
`define HBUT_CHECK(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("hbut check failed");
// Next-cycle implication, disabled while reset is asserted.
`define HBUT_CHECK_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("hbut next-cycle check failed");
`else
`define HBUT_CHECK(label, clk, rst_n, ante, cons)
`define HBUT_CHECK_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

### rtl/hbut_pkg.sv
// Types and constants for the half-bit tick UART transceiver.
package hbut_pkg;

    // Event codes carried on the command field
    localparam logic [1:0] CMD_TICK  = 2'd0;
    localparam logic [1:0] CMD_WRITE = 2'd1;
    localparam logic [1:0] CMD_EDGE  = 2'd2;

    // Configuration register indexes
    localparam logic [1:0] REG_DATA_BITS   = 2'd0;
    localparam logic [1:0] REG_PARITY_MODE = 2'd1;
    localparam logic [1:0] REG_STOP_BITS   = 2'd2;

    // Parity codes
    localparam logic [1:0] PAR_EVEN = 2'd1;
    localparam logic [1:0] PAR_ODD  = 2'd2;

    localparam int RX_SHIFT_W = 11;
    localparam int TX_SHIFT_W = 12;

    // Effective (clamped) frame format shared by both directions
    typedef struct packed {
        logic [3:0] data_bits;  // 5..8
        logic       par_en;
        logic       par_odd;
        logic       two_stops;
    } frame_cfg_t;

    typedef struct packed {
        logic       valid;
        logic [7:0] data;
    } rx_res_t;

    typedef struct packed {
        logic level;
        logic busy;
        logic refused;
    } tx_res_t;

    typedef struct packed {
        logic       tx_line;
        logic       rx_valid;
        logic [7:0] rx_byte;
        logic       tx_busy;
        logic       write_refused;
    } result_t;

endpackage

### rtl/hbut_rx.sv
// Receiver: arms on a falling edge, samples on half-bit ticks, delivers the low byte.
`include "half_bit_tick_uart_transceiver_macros.svh"

module hbut_rx (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               en,
    input  logic [1:0]         cmd,
    input  logic               level,
    input  hbut_pkg::frame_cfg_t cfg,
    output hbut_pkg::rx_res_t  res
);
    import hbut_pkg::*;

    logic                  active_reg, active_next;
    logic [3:0]            samples_reg, samples_next;
    logic [1:0]            tick_reg, tick_next;
    logic [RX_SHIFT_W-1:0] shift_reg, shift_next;

    logic [3:0]            frame_len;
    logic [RX_SHIFT_W-1:0] top_bit;
    logic [1:0]            tick_inc;
    logic [3:0]            samples_inc;

    // Frame length and the bit position where a new sample lands
    assign frame_len = cfg.data_bits + (cfg.two_stops ? 4'd2 : 4'd1) + {3'd0, cfg.par_en};
    assign top_bit   = RX_SHIFT_W'(1) << (frame_len - 4'd1);
    assign tick_inc  = tick_reg + 2'd1;
    assign samples_inc = samples_reg + 4'd1;

    // Next state for one event
    always_comb begin
        active_next  = active_reg;
        samples_next = samples_reg;
        tick_next    = tick_reg;
        shift_next   = shift_reg;
        res          = '0;
        case (cmd)
            CMD_TICK: begin
                if (active_reg) begin
                    tick_next = tick_inc;
                    if (samples_reg == 4'd0) begin
                        // first data bit center is 1.5 bit times after the edge
                        if (tick_inc == 2'd3) begin
                            shift_next   = shift_reg | (level ? top_bit : '0);
                            samples_next = 4'd1;
                            tick_next    = 2'd0;
                        end
                    end else if (tick_inc[1]) begin
                        shift_next   = {1'b0, shift_reg[RX_SHIFT_W-1:1]} |
                                       (level ? top_bit : '0);
                        samples_next = samples_inc;
                        tick_next    = 2'd0;
                        if (samples_inc >= frame_len) begin
                            res.valid    = 1'b1;
                            res.data     = shift_next[7:0];
                            active_next  = 1'b0;
                            samples_next = 4'd0;
                        end
                    end
                end
            end
            CMD_EDGE: begin
                if (!active_reg) begin
                    active_next  = 1'b1;
                    shift_next   = '0;
                    samples_next = 4'd0;
                    tick_next    = 2'd0;
                end
            end
            default: ;
        endcase
    end

    // State registers advance on each accepted beat
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg  <= 1'b0;
            samples_reg <= 4'd0;
            tick_reg    <= 2'd0;
            shift_reg   <= '0;
        end else if (en) begin
            active_reg  <= active_next;
            samples_reg <= samples_next;
            tick_reg    <= tick_next;
            shift_reg   <= shift_next;
        end
    end

    `HBUT_CHECK(a_rx_idle_clean, aclk, aresetn, !active_reg, samples_reg == 4'd0 && tick_reg == 2'd0)
    `HBUT_CHECK(a_rx_bit_spacing, aclk, aresetn, active_reg && samples_reg != 4'd0, tick_reg < 2'd2)
    `HBUT_CHECK(a_rx_count_bound, aclk, aresetn, 1'b1, samples_reg <= 4'd11)

endmodule

### rtl/hbut_tx.sv
// Transmitter: frames a byte and shifts it out one bit per two half-bit ticks.
`include "half_bit_tick_uart_transceiver_macros.svh"

module hbut_tx (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 en,
    input  logic [1:0]           cmd,
    input  logic [7:0]           tx_byte,
    input  hbut_pkg::frame_cfg_t cfg,
    output hbut_pkg::tx_res_t    res
);
    import hbut_pkg::*;

    logic                  active_reg, active_next;
    logic [3:0]            bits_left_reg, bits_left_next;
    logic                  tick_reg, tick_next;
    logic [TX_SHIFT_W-1:0] shift_reg, shift_next;
    logic                  level_reg, level_next;

    logic [8:0]            data_mask;
    logic [7:0]            data;
    logic                  pbit;
    logic [2:0]            tail;
    logic [3:0]            nbits;
    logic [TX_SHIFT_W-1:0] frame;
    logic [3:0]            bits_dec;

    // Frame build: start bit in bit 0, data LSB first, parity, stop bits
    assign data_mask = (9'd1 << cfg.data_bits) - 9'd1;
    assign data      = tx_byte & data_mask[7:0];
    assign pbit      = cfg.par_en & ((^data) ^ cfg.par_odd);
    assign tail      = cfg.par_en ? {cfg.two_stops, 1'b1, pbit}
                                  : {1'b0, cfg.two_stops, 1'b1};
    assign nbits     = cfg.data_bits + 4'd2 + {3'd0, cfg.par_en} +
                       (cfg.two_stops ? 4'd2 : 4'd1);
    assign frame     = (TX_SHIFT_W'(data) | (TX_SHIFT_W'(tail) << cfg.data_bits)) << 1;
    assign bits_dec  = bits_left_reg - 4'd1;

    // Next state for one event
    always_comb begin
        active_next    = active_reg;
        bits_left_next = bits_left_reg;
        tick_next      = tick_reg;
        shift_next     = shift_reg;
        level_next     = level_reg;
        res.refused    = 1'b0;
        case (cmd)
            CMD_TICK: begin
                if (active_reg) begin
                    tick_next = ~tick_reg;
                    // bit boundary on every second tick
                    if (tick_reg) begin
                        bits_left_next = bits_dec;
                        if (bits_dec == 4'd0) begin
                            active_next = 1'b0;
                        end else begin
                            level_next = shift_reg[0];
                            shift_next = {1'b0, shift_reg[TX_SHIFT_W-1:1]};
                        end
                    end
                end
            end
            CMD_WRITE: begin
                if (active_reg) begin
                    res.refused = 1'b1;
                end else begin
                    shift_next     = frame;
                    bits_left_next = nbits;
                    tick_next      = 1'b0;
                    active_next    = 1'b1;
                end
            end
            default: ;
        endcase
        res.level = level_next;
        res.busy  = active_next;
    end

    // State registers advance on each accepted beat
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg    <= 1'b0;
            bits_left_reg <= 4'd0;
            tick_reg      <= 1'b0;
            shift_reg     <= '0;
            level_reg     <= 1'b1;
        end else if (en) begin
            active_reg    <= active_next;
            bits_left_reg <= bits_left_next;
            tick_reg      <= tick_next;
            shift_reg     <= shift_next;
            level_reg     <= level_next;
        end
    end

    `HBUT_CHECK(a_tx_idle_clean, aclk, aresetn, !active_reg, bits_left_reg == 4'd0 && !tick_reg)
    `HBUT_CHECK(a_tx_busy_has_bits, aclk, aresetn, active_reg, bits_left_reg != 4'd0)
    `HBUT_CHECK(a_tx_count_bound, aclk, aresetn, 1'b1, bits_left_reg <= 4'd13)

endmodule

### rtl/half_bit_tick_uart_transceiver.sv
// Top level of the half-bit tick UART transceiver: config registers, rx/tx engines, output skid.
// One event beat (half-bit tick, byte write or receive falling edge) is taken per clock cycle
// while s_ready is high; its result beat is registered in the result register, or in the skid
// register while that holds an undelivered result, and the rx and tx state registers update on
// the same edge. A two-entry output stage (result plus skid register) keeps s_ready high for
// one extra beat after m_ready drops; s_ready falls only when both hold undelivered results.
// Configuration writes apply immediately and should be made while no beat is outstanding.
`include "half_bit_tick_uart_transceiver_macros.svh"

module half_bit_tick_uart_transceiver (
    input  logic       aclk,
    input  logic       aresetn,
    // configuration write port
    input  logic       cfg_we,
    input  logic [1:0] cfg_index,
    input  logic [3:0] cfg_wdata,
    // event input
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [1:0] s_command,
    input  logic       s_rx_level,
    input  logic [7:0] s_tx_byte,
    // result output
    output logic       m_valid,
    input  logic       m_ready,
    output logic       m_tx_line,
    output logic       m_rx_valid,
    output logic [7:0] m_rx_byte,
    output logic       m_tx_busy,
    output logic       m_write_refused
);
    import hbut_pkg::*;

    logic [3:0] data_bits_reg;
    logic [1:0] parity_mode_reg;
    logic [1:0] stop_bits_reg;
    frame_cfg_t cfg;

    logic    push, pop;
    rx_res_t rx_res;
    tx_res_t tx_res;
    result_t new_res;
    result_t out_reg, skid_reg;
    logic    out_valid_reg, skid_valid_reg;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            data_bits_reg   <= 4'd8;
            parity_mode_reg <= 2'd0;
            stop_bits_reg   <= 2'd1;
        end else if (cfg_we) begin
            case (cfg_index)
                REG_DATA_BITS:   data_bits_reg   <= cfg_wdata;
                REG_PARITY_MODE: parity_mode_reg <= cfg_wdata[1:0];
                REG_STOP_BITS:   stop_bits_reg   <= cfg_wdata[1:0];
                default: ;
            endcase
        end
    end

    // Clamp to the supported frame formats
    always_comb begin
        if (data_bits_reg < 4'd5) begin
            cfg.data_bits = 4'd5;
        end else if (data_bits_reg > 4'd8) begin
            cfg.data_bits = 4'd8;
        end else begin
            cfg.data_bits = data_bits_reg;
        end
        cfg.par_en    = (parity_mode_reg == PAR_EVEN) || (parity_mode_reg == PAR_ODD);
        cfg.par_odd   = (parity_mode_reg == PAR_ODD);
        cfg.two_stops = (stop_bits_reg != 2'd1);
    end

    assign s_ready = !skid_valid_reg;
    assign push    = s_valid && s_ready;
    assign pop     = out_valid_reg && m_ready;

    hbut_rx u_rx (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (push),
        .cmd     (s_command),
        .level   (s_rx_level),
        .cfg     (cfg),
        .res     (rx_res)
    );

    hbut_tx u_tx (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (push),
        .cmd     (s_command),
        .tx_byte (s_tx_byte),
        .cfg     (cfg),
        .res     (tx_res)
    );

    // Result beat for the current event
    always_comb begin
        new_res.tx_line       = tx_res.level;
        new_res.rx_valid      = rx_res.valid;
        new_res.rx_byte       = rx_res.data;
        new_res.tx_busy       = tx_res.busy;
        new_res.write_refused = tx_res.refused;
    end

    // Output register with skid entry
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            if (pop && !push) begin
                if (skid_valid_reg) begin
                    skid_valid_reg <= 1'b0;
                end else begin
                    out_valid_reg <= 1'b0;
                end
            end else if (push && !pop) begin
                if (out_valid_reg) begin
                    skid_valid_reg <= 1'b1;
                end else begin
                    out_valid_reg <= 1'b1;
                end
            end
        end
    end

    // Payload movement, no reset needed
    always_ff @(posedge aclk) begin
        if (pop) begin
            if (skid_valid_reg) begin
                out_reg <= skid_reg;
                if (push) begin
                    skid_reg <= new_res;
                end
            end else if (push) begin
                out_reg <= new_res;
            end
        end else if (push) begin
            if (out_valid_reg) begin
                skid_reg <= new_res;
            end else begin
                out_reg <= new_res;
            end
        end
    end

    assign m_valid         = out_valid_reg;
    assign m_tx_line       = out_reg.tx_line;
    assign m_rx_valid      = out_reg.rx_valid;
    assign m_rx_byte       = out_reg.rx_byte;
    assign m_tx_busy       = out_reg.tx_busy;
    assign m_write_refused = out_reg.write_refused;

    `HBUT_CHECK(a_refused_means_busy, aclk, aresetn, m_valid && m_write_refused, m_tx_busy)
    `HBUT_CHECK(a_rx_byte_quiet, aclk, aresetn, m_valid && !m_rx_valid, m_rx_byte == 8'd0)
    `HBUT_CHECK(a_refused_only_on_write, aclk, aresetn, push && tx_res.refused, s_command == CMD_WRITE)
    `HBUT_CHECK_NEXT(a_skid_fill, aclk, aresetn, push && !pop && out_valid_reg, skid_valid_reg)

endmodule
